/* rtl/lcls_pkg.sv */
// ----------------------------------------------------------------------------
// LED cube layer scanner package
// Request codes, sequencer states and fixed widths shared by the scanner,
// its frame store and its port checker.
// ----------------------------------------------------------------------------
package lcls_pkg;

	// Width of the layer enable bus.
	localparam int SEL_W = 8;

	// Width of one coordinate field on the request channel.
	localparam int COORD_W = 3;

	// Request codes.
	typedef enum logic [1:0] {
		ACT_SET   = 2'd0,
		ACT_CLEAR = 2'd1,
		ACT_READ  = 2'd2,
		ACT_TICK  = 2'd3
	} action_t;

	// Sequencer states, one-hot.
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_WRITE = 5'b00010,
		ST_READ  = 5'b00100,
		ST_LOAD  = 5'b01000,
		ST_SHIFT = 5'b10000
	} state_t;

endpackage

/* rtl/lcls_frame_store.sv */
// ----------------------------------------------------------------------------
// LED cube frame store
// One word of SIDE pixels per (column, layer) pair, one write port and one
// registered read port. Per-word valid bits make unwritten words read as zero.
// ----------------------------------------------------------------------------
module lcls_frame_store
	import lcls_pkg::*;
#(
	parameter int SIDE = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               rd_en,
	input  logic [$clog2(SIDE*SIDE)-1:0]       rd_addr,
	output logic [SIDE-1:0]                    rd_data,
	input  logic                               wr_en,
	input  logic [$clog2(SIDE*SIDE)-1:0]       wr_addr,
	input  logic [SIDE-1:0]                    wr_data
);

	localparam int DEPTH = SIDE * SIDE;

	logic [SIDE-1:0]  mem [DEPTH];
	logic [SIDE-1:0]  rd_word_q;
	logic [DEPTH-1:0] word_vld_q;
	logic             rd_vld_q;

	// Word array: write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_word_q <= mem[rd_addr];
		end
	end

	// Valid bits: a word counts as all zeros until its first write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_vld_q <= '0;
			rd_vld_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				word_vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= word_vld_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_vld_q ? rd_word_q : '0;

endmodule

/* rtl/led_cube_layer_scanner_unit.sv */
// Timing: a set or clear goes on to the write state unless a coordinate is out of range;
// a read result passes the frame store read register, then the output register once free.
// Scan: a tick makes one memory read and one load, then one pixel per cycle out of the
// row shift register for SIDE*SIDE bits, while the output is not stalled.
// Reset: the frame store reads as all zeros through per-row valid bits (no clearing
// pass), the layer counter starts at zero and both channels come up empty.
// ----------------------------------------------------------------------------
// LED cube layer scanner
// Keeps a one-bit-per-LED frame store, services set, clear and read requests,
// and on each scan tick serializes one layer with a one-hot layer enable.
// ----------------------------------------------------------------------------
module led_cube_layer_scanner_unit
	import lcls_pkg::*;
#(
	parameter int SIDE = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	// Request channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         action,
	input  logic [COORD_W-1:0] pos_x,
	input  logic [COORD_W-1:0] pos_y,
	input  logic [COORD_W-1:0] pos_z,
	// Result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic               serial_bit,
	output logic [SEL_W-1:0]   layer_select,
	output logic               latch_pulse,
	output logic               read_value,
	output logic               last
);

	localparam int RW = $clog2(SIDE);
	localparam int AW = $clog2(SIDE * SIDE);

	state_t             state_q;
	action_t            act_q;
	logic [COORD_W-1:0] x_q;
	logic               ok_q;
	logic [AW-1:0]      waddr_q;
	logic [RW-1:0]      layer_q;
	logic [RW-1:0]      row_q;
	logic [RW-1:0]      bit_q;
	logic [SIDE-1:0]    sreg_q;

	logic               out_valid_q;
	logic               serial_bit_q;
	logic [SEL_W-1:0]   layer_select_q;
	logic               latch_pulse_q;
	logic               read_value_q;
	logic               last_q;

	logic               in_take;
	logic               coord_ok;
	logic [AW-1:0]      in_addr;
	logic               slot_free;
	logic               last_bit;
	logic               last_row;
	logic [RW-1:0]      row_nxt;
	logic [RW-1:0]      row_pre;
	logic [SEL_W-1:0]   sel;
	logic [SIDE-1:0]    mask;
	logic [SIDE-1:0]    rd_shift;

	logic               rd_en;
	logic [AW-1:0]      rd_addr;
	logic [SIDE-1:0]    rd_data;
	logic               wr_en;
	logic [SIDE-1:0]    wr_data;

	logic               out_load;
	logic               nxt_serial_bit;
	logic [SEL_W-1:0]   nxt_layer_select;
	logic               nxt_latch_pulse;
	logic               nxt_read_value;
	logic               nxt_last;

	// Word address of a (column, layer) pair.
	function automatic logic [AW-1:0] word_addr(input logic [AW-1:0] col,
			input logic [AW-1:0] lyr);
		return AW'(col * AW'(SIDE) + lyr);
	endfunction

	// Request decode.
	assign in_stall = (state_q != ST_IDLE);
	assign in_take  = in_valid && (state_q == ST_IDLE);
	assign coord_ok = (int'(pos_x) < SIDE) && (int'(pos_y) < SIDE) && (int'(pos_z) < SIDE);
	assign in_addr  = word_addr(AW'(pos_y), AW'(pos_z));

	// Scan position.
	assign slot_free = !out_valid_q || !out_stall;
	assign last_bit  = (bit_q == RW'(SIDE - 1));
	assign last_row  = (row_q == RW'(SIDE - 1));
	assign row_nxt   = RW'(row_q + RW'(1));
	assign row_pre   = RW'((RW+1)'(row_q) + (RW+1)'(2));
	// Layers numbered eight or more shift the one out of the bus and enable nothing.
	assign sel       = SEL_W'(1) << layer_q;

	// Pixel access within a word.
	assign mask     = SIDE'(1) << x_q;
	assign rd_shift = rd_data >> x_q;

	// Frame store port control.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = in_addr;
		wr_en   = 1'b0;
		wr_data = (act_q == ACT_SET) ? (rd_data | mask) : (rd_data & ~mask);
		case (state_q)
			ST_IDLE: begin
				rd_en = in_take;
				if (action == ACT_TICK) begin
					rd_addr = word_addr('0, AW'(layer_q));
				end
			end
			ST_WRITE: begin
				wr_en = 1'b1;
			end
			ST_LOAD: begin
				rd_en   = 1'b1;
				rd_addr = word_addr(AW'(row_nxt), AW'(layer_q));
			end
			ST_SHIFT: begin
				rd_en   = slot_free && last_bit && !last_row && (row_nxt != RW'(SIDE - 1));
				rd_addr = word_addr(AW'(row_pre), AW'(layer_q));
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	// Next result item.
	always_comb begin
		out_load         = 1'b0;
		nxt_serial_bit   = 1'b0;
		nxt_layer_select = '0;
		nxt_latch_pulse  = 1'b0;
		nxt_read_value   = 1'b0;
		nxt_last         = 1'b0;
		case (state_q)
			ST_READ: begin
				out_load       = slot_free;
				nxt_read_value = ok_q && rd_shift[0];
				nxt_last       = 1'b1;
			end
			ST_SHIFT: begin
				out_load         = slot_free;
				nxt_serial_bit   = sreg_q[0];
				nxt_layer_select = sel;
				nxt_latch_pulse  = last_bit && last_row;
				nxt_last         = last_bit && last_row;
			end
			default: begin
				out_load = 1'b0;
			end
		endcase
	end

	// Sequencer and layer counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			layer_q <= '0;
			row_q   <= '0;
			bit_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						case (action)
							ACT_SET, ACT_CLEAR: state_q <= coord_ok ? ST_WRITE : ST_IDLE;
							ACT_READ:           state_q <= ST_READ;
							ACT_TICK: begin
								row_q   <= '0;
								state_q <= ST_LOAD;
							end
							default:            state_q <= ST_IDLE;
						endcase
					end
				end
				ST_WRITE: begin
					state_q <= ST_IDLE;
				end
				ST_READ: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_LOAD: begin
					bit_q   <= '0;
					state_q <= ST_SHIFT;
				end
				ST_SHIFT: begin
					if (slot_free) begin
						if (last_bit) begin
							bit_q <= '0;
							if (last_row) begin
								layer_q <= (layer_q == RW'(SIDE - 1)) ? '0 : RW'(layer_q + RW'(1));
								state_q <= ST_IDLE;
							end else begin
								row_q <= row_nxt;
							end
						end else begin
							bit_q <= RW'(bit_q + RW'(1));
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Request capture and row shift register.
	always_ff @(posedge clk) begin
		if (in_take) begin
			act_q   <= action_t'(action);
			x_q     <= pos_x;
			ok_q    <= coord_ok;
			waddr_q <= in_addr;
		end
		if (state_q == ST_LOAD) begin
			sreg_q <= rd_data;
		end else if ((state_q == ST_SHIFT) && slot_free) begin
			sreg_q <= last_bit ? rd_data : (sreg_q >> 1);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			serial_bit_q   <= nxt_serial_bit;
			layer_select_q <= nxt_layer_select;
			latch_pulse_q  <= nxt_latch_pulse;
			read_value_q   <= nxt_read_value;
			last_q         <= nxt_last;
		end
	end

	assign out_valid    = out_valid_q;
	assign serial_bit   = serial_bit_q;
	assign layer_select = layer_select_q;
	assign latch_pulse  = latch_pulse_q;
	assign read_value   = read_value_q;
	assign last         = last_q;

	// Frame store.
	lcls_frame_store #(
		.SIDE (SIDE)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (waddr_q),
		.wr_data (wr_data)
	);

endmodule

/* rtl/lcls_checker.sv */
// ----------------------------------------------------------------------------
// LED cube layer scanner port checker
// Watches the scanner's ports and flags results whose flags contradict each
// other, a stalled result that changes, or a request that is not held off.
// ----------------------------------------------------------------------------
module lcls_checker
	import lcls_pkg::*;
(
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic [1:0]       action,
	input logic             out_valid,
	input logic             out_stall,
	input logic             serial_bit,
	input logic [SEL_W-1:0] layer_select,
	input logic             latch_pulse,
	input logic             read_value,
	input logic             last
);

	// A stalled result transfer keeps its valid and its fields.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(serial_bit)
			&& $stable(layer_select) && $stable(latch_pulse)
			&& $stable(read_value) && $stable(last))
		else $error("stalled result changed");

	// A read or a scan tick always produces a result, so the next request waits.
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (action == ACT_READ || action == ACT_TICK) |=> in_stall)
		else $error("request channel open while a result is pending");

	// The latch comes only on the final scan bit, which carries at most one layer enable.
	a_latch_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && latch_pulse |-> last && !read_value && $onehot0(layer_select))
		else $error("latch pulse with inconsistent flags");

	// A set read value belongs to a read result, which has no scan fields.
	a_read_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_value |-> last && !latch_pulse && !serial_bit
			&& (layer_select == '0))
		else $error("read result carries scan fields");

endmodule

bind led_cube_layer_scanner_unit lcls_checker u_lcls_checker (.*);

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// LED cube layer scanner testbench
// Drives set, clear, read and scan tick requests into the scanner. A directed
// table runs first, then random traffic. Every result transfer is checked
// against a cycle-free model of the frame store and the layer counter, with
// random idle bursts on the request side and stall bursts on the result side.
// ----------------------------------------------------------------------------
module tb
	import lcls_pkg::*;
();

	localparam int SIDE      = 8;
	localparam int N_RANDOM  = 147;
	localparam int N_STEADY  = 30;
	localparam int PAUSE_AT  = 70;
	localparam int DRAIN_CYC = 80;
	localparam int MAX_SHOWN = 10;

	// One result transfer as seen on the output ports.
	typedef struct packed {
		logic             serial_bit;
		logic [SEL_W-1:0] layer_select;
		logic             latch_pulse;
		logic             read_value;
		logic             last;
	} pixel_out_t;

	// One directed request; typed rows carry a read value known in advance.
	typedef struct {
		action_t            act;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		bit                 typed;
		bit                 rv;
	} dir_row_t;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               in_valid     = 1'b0;
	logic               in_stall;
	logic [1:0]         action       = ACT_SET;
	logic [COORD_W-1:0] pos_x        = '0;
	logic [COORD_W-1:0] pos_y        = '0;
	logic [COORD_W-1:0] pos_z        = '0;
	logic               out_valid;
	logic               out_stall    = 1'b0;
	logic               serial_bit;
	logic [SEL_W-1:0]   layer_select;
	logic               latch_pulse;
	logic               read_value;
	logic               last;

	// Model state: one bit per LED indexed [x][y][z], and the next layer to scan.
	bit                 frame_bits [SIDE][SIDE][SIDE];
	int                 scan_layer   = 0;
	pixel_out_t         pending_pixels [$];
	logic [8:0]         touched [$];
	int                 mismatches   = 0;
	bit                 steady       = 1'b0;
	int                 stall_left   = 0;
	int                 calm_left    = 0;

	// Corners, both write kinds, reads after reset and after writes, and scans.
	dir_row_t dir_rows [23] = '{
		'{ACT_READ,  3'd0, 3'd0, 3'd0, 1'b1, 1'b0},
		'{ACT_READ,  3'd7, 3'd7, 3'd7, 1'b1, 1'b0},
		'{ACT_TICK,  3'd0, 3'd0, 3'd0, 1'b0, 1'b0},
		'{ACT_SET,   3'd0, 3'd0, 3'd0, 1'b0, 1'b0},
		'{ACT_SET,   3'd7, 3'd7, 3'd7, 1'b0, 1'b0},
		'{ACT_SET,   3'd7, 3'd0, 3'd1, 1'b0, 1'b0},
		'{ACT_SET,   3'd0, 3'd7, 3'd1, 1'b0, 1'b0},
		'{ACT_SET,   3'd5, 3'd3, 3'd1, 1'b0, 1'b0},
		'{ACT_READ,  3'd0, 3'd0, 3'd0, 1'b1, 1'b1},
		'{ACT_READ,  3'd7, 3'd7, 3'd7, 1'b1, 1'b1},
		'{ACT_READ,  3'd7, 3'd0, 3'd1, 1'b1, 1'b1},
		'{ACT_TICK,  3'd7, 3'd7, 3'd7, 1'b0, 1'b0},
		'{ACT_CLEAR, 3'd7, 3'd7, 3'd7, 1'b0, 1'b0},
		'{ACT_READ,  3'd7, 3'd7, 3'd7, 1'b1, 1'b0},
		'{ACT_CLEAR, 3'd0, 3'd0, 3'd0, 1'b0, 1'b0},
		'{ACT_READ,  3'd0, 3'd0, 3'd0, 1'b1, 1'b0},
		'{ACT_CLEAR, 3'd3, 3'd3, 3'd3, 1'b0, 1'b0},
		'{ACT_READ,  3'd3, 3'd3, 3'd3, 1'b1, 1'b0},
		'{ACT_SET,   3'd2, 3'd6, 3'd2, 1'b0, 1'b0},
		'{ACT_SET,   3'd7, 3'd7, 3'd2, 1'b0, 1'b0},
		'{ACT_TICK,  3'd5, 3'd2, 3'd6, 1'b0, 1'b0},
		'{ACT_READ,  3'd0, 3'd7, 3'd1, 1'b1, 1'b1},
		'{ACT_READ,  3'd5, 3'd3, 3'd1, 1'b1, 1'b1}
	};

	led_cube_layer_scanner_unit #(
		.SIDE(SIDE)
	) uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.serial_bit  (serial_bit),
		.layer_select(layer_select),
		.latch_pulse (latch_pulse),
		.read_value  (read_value),
		.last        (last)
	);

	always #5 clk = ~clk;

	// Update the cube model for one accepted request and queue its results.
	task automatic predict_cube(action_t act, logic [COORD_W-1:0] x,
			logic [COORD_W-1:0] y, logic [COORD_W-1:0] z);
		pixel_out_t r;
		bit         ok;
		ok = (x < SIDE) && (y < SIDE) && (z < SIDE);
		case (act)
		ACT_SET, ACT_CLEAR: begin
			if (ok)
				frame_bits[x][y][z] = (act == ACT_SET);
		end
		ACT_READ: begin
			r = '0;
			r.read_value = ok ? frame_bits[x][y][z] : 1'b0;
			r.last = 1'b1;
			pending_pixels.push_back(r);
		end
		default: begin
			// Columns are the outer loop, rows the inner one.
			for (int col = 0; col < SIDE; col++) begin
				for (int row = 0; row < SIDE; row++) begin
					r = '0;
					r.serial_bit = frame_bits[row][col][scan_layer];
					if (scan_layer < SEL_W)
						r.layer_select[scan_layer] = 1'b1;
					r.latch_pulse = (col == SIDE - 1) && (row == SIDE - 1);
					r.last = r.latch_pulse;
					pending_pixels.push_back(r);
				end
			end
			scan_layer = (scan_layer + 1) % SIDE;
		end
		endcase
	endtask

	// Present one request, wait for its transfer, then maybe idle for a burst.
	task automatic send_request(action_t act, logic [COORD_W-1:0] x,
			logic [COORD_W-1:0] y, logic [COORD_W-1:0] z, bit typed, bit rv);
		pixel_out_t r;
		in_valid <= 1'b1;
		action   <= act;
		pos_x    <= x;
		pos_y    <= y;
		pos_z    <= z;
		do @(posedge clk); while (in_stall);
		if (typed) begin
			r = '0;
			r.read_value = rv;
			r.last = 1'b1;
			pending_pixels.push_back(r);
		end else begin
			predict_cube(act, x, y, z);
		end
		if (!steady && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	// Random request; coordinates often revisit lit pixels or the next scanned layer.
	task automatic send_random();
		int                 pick;
		action_t            act;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		pick = $urandom_range(0, 99);
		if (pick < 35)
			act = ACT_SET;
		else if (pick < 55)
			act = ACT_CLEAR;
		else if (pick < 80)
			act = ACT_READ;
		else
			act = ACT_TICK;
		{x, y, z} = 9'($urandom);
		if (act != ACT_TICK && touched.size() != 0 && $urandom_range(0, 1) == 1)
			{x, y, z} = touched[$urandom_range(0, touched.size() - 1)];
		else if ($urandom_range(0, 3) == 0)
			z = COORD_W'(scan_layer);
		if (act == ACT_SET) begin
			touched.push_back({x, y, z});
			if (touched.size() > 16)
				void'(touched.pop_front());
		end
		send_request(act, x, y, z, 1'b0, 1'b0);
	endtask

	// Result side stalls in random bursts, with calm stretches between.
	always @(posedge clk) begin
		if (steady || !arst_n) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (calm_left > 0) begin
			out_stall <= 1'b0;
			calm_left <= calm_left - 1;
		end else begin
			case ($urandom_range(0, 9))
			0, 1: begin
				out_stall  <= 1'b1;
				stall_left <= $urandom_range(0, 17);
			end
			2: begin
				out_stall <= 1'b0;
				calm_left <= $urandom_range(20, 150);
			end
			default: out_stall <= 1'b0;
			endcase
		end
	end

	// Compare every result transfer with the oldest expected pixel.
	always @(posedge clk) begin : check_results
		pixel_out_t got;
		pixel_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = {serial_bit, layer_select, latch_pulse, read_value, last};
			if (pending_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("unexpected result: bit %0b sel %h latch %0b read %0b last %0b",
						got.serial_bit, got.layer_select, got.latch_pulse,
						got.read_value, got.last);
			end else begin
				want = pending_pixels.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("mismatch: bit %0b/%0b sel %h/%h latch %0b/%0b read %0b/%0b last %0b/%0b (exp/act)",
							want.serial_bit, got.serial_bit,
							want.layer_select, got.layer_select,
							want.latch_pulse, got.latch_pulse,
							want.read_value, got.read_value,
							want.last, got.last);
				end
			end
		end
	end

	// Main sequence: reset, directed table, random traffic, drain.
	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[i])
			send_request(dir_rows[i].act, dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
				dir_rows[i].typed, dir_rows[i].rv);
		for (int n = 0; n < N_RANDOM; n++) begin
			// Hold off once until the scanner has delivered everything.
			if (n == PAUSE_AT) begin
				in_valid <= 1'b0;
				do @(posedge clk); while (pending_pixels.size() != 0);
			end
			if (n == N_RANDOM - N_STEADY)
				steady = 1'b1;
			send_random();
		end
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_pixels.size() != 0);
		repeat (DRAIN_CYC) @(posedge clk);
		if (mismatches == 0 && pending_pixels.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#10000000;
		$display("tb NOT OK");
		$finish;
	end

endmodule

/* sim.f */
rtl/lcls_pkg.sv
rtl/lcls_frame_store.sv
rtl/led_cube_layer_scanner_unit.sv
rtl/lcls_checker.sv
sim/tb.sv
